>>> sv/cba_pkg.sv
// Shared types and constants for the chunked bump allocator.
// No dependencies; imported by chunked_bump_allocator.
package cba_pkg;

    localparam int NUM_CHUNKS      = 16;
    localparam int MAX_CHUNK_BYTES = 65536;

    // Field widths
    localparam int KIND_W   = 2;
    localparam int SIZE_W   = 17;
    localparam int ALIGN_W  = 4;
    localparam int QCHUNK_W = 4;
    localparam int QOFF_W   = 16;
    localparam int STATUS_W = 2;
    localparam int GCHUNK_W = 4;
    localparam int GOFF_W   = 17;
    localparam int FILL_W   = 17;
    localparam int MAXAL_W  = 3;

    // Internal widths
    localparam int IDX_W  = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int OPEN_W = $clog2(NUM_CHUNKS + 1);
    localparam int SUM_W  = FILL_W + 2;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ALIGN = 2'd1;

    localparam logic [FILL_W-1:0]  CAPACITY_RESET  = FILL_W'(8 * (1 << 10));
    localparam logic [MAXAL_W-1:0] MAX_ALIGN_RESET = MAXAL_W'(4);
    localparam logic [FILL_W-1:0]  CAPACITY_LIMIT  = FILL_W'(MAX_CHUNK_BYTES);

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_BIG  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_CHUNK = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [SIZE_W-1:0]   request_size;
        logic [ALIGN_W-1:0]  align_log2;
        logic [QCHUNK_W-1:0] query_chunk;
        logic [QOFF_W-1:0]   query_offset;
    } t_alloc_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [GCHUNK_W-1:0] grant_chunk;
        logic [GOFF_W-1:0]   grant_offset;
        logic                owned;
    } t_alloc_rsp;

endpackage

>>> sv/chunked_bump_allocator.sv
// Chunked bump allocator: first-fit scan over per-chunk fill levels.
// Depends on cba_pkg (types, widths, codes).
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+------------------------------
//  in      | i_in_valid  | o_in_ready  | i_in_data  (t_alloc_req)
//  out     | o_out_valid | i_out_ready | o_out_data (t_alloc_rsp)
//  cfg     | i_cfg_valid | o_cfg_ready | i_cfg_index, i_cfg_data
//
// An item is accepted, then scanned: the shared round-up/add/compare unit
// visits one chunk fill per cycle, and a scan with no fit opens a new chunk
// if one is left. Query, release and oversized items finish in the first
// scan step. Synchronous active-low reset clears the open-chunk count and
// restores the register defaults; fill entries past the open count are
// never read. A result that is not yet taken holds the final scan step.
module chunked_bump_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  cba_pkg::t_alloc_req           i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output cba_pkg::t_alloc_rsp           o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cba_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cba_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cba_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state              r_state, n_state;
    t_alloc_req          r_req;
    t_alloc_rsp          r_out, n_out;
    logic                r_out_valid;
    logic [OPEN_W-1:0]   r_idx, n_idx;
    logic [OPEN_W-1:0]   r_open, n_open;
    logic [FILL_W-1:0]   r_capacity;
    logic [MAXAL_W-1:0]  r_max_align;
    logic [FILL_W-1:0]   r_fill [NUM_CHUNKS];

    logic [IDX_W-1:0]    rd_addr;
    logic [FILL_W-1:0]   rd_fill;
    logic [FILL_W-1:0]   cap_eff;
    logic [MAXAL_W-1:0]  lg;
    logic [SUM_W-1:0]    mask;
    logic [SUM_W-1:0]    rounded;
    logic [SUM_W-1:0]    new_fill;
    logic                done;
    logic                out_free;
    logic                commit;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [FILL_W-1:0]   wr_data;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_free    = !r_out_valid || i_out_ready;

    // Shared round-up / add / compare unit
    assign rd_addr  = (r_req.kind == KIND_QUERY) ? IDX_W'(r_req.query_chunk)
                                                 : r_idx[IDX_W-1:0];
    assign rd_fill  = r_fill[rd_addr];
    assign cap_eff  = (r_capacity > CAPACITY_LIMIT) ? CAPACITY_LIMIT : r_capacity;
    assign lg       = ({1'b0, r_max_align} < r_req.align_log2) ? r_max_align
                                                               : MAXAL_W'(r_req.align_log2);
    assign mask     = ({{(SUM_W-1){1'b0}}, 1'b1} << lg) - SUM_W'(1);
    assign rounded  = ({2'b00, rd_fill} + mask) & ~mask;
    assign new_fill = rounded + SUM_W'(r_req.request_size);

    always_comb begin
        done    = 1'b1;
        n_out   = '0;
        n_open  = r_open;
        n_idx   = r_idx;
        wr_en   = 1'b0;
        wr_addr = r_idx[IDX_W-1:0];
        wr_data = new_fill[FILL_W-1:0];
        case (r_req.kind)
            KIND_ALLOC: begin
                if (r_req.request_size > cap_eff) begin
                    n_out.status = ST_TOO_BIG;
                end else if (r_idx < r_open) begin
                    if (new_fill <= SUM_W'(cap_eff)) begin
                        wr_en              = 1'b1;
                        n_out.status       = ST_OK;
                        n_out.grant_chunk  = GCHUNK_W'(r_idx);
                        n_out.grant_offset = rounded[GOFF_W-1:0];
                    end else begin
                        // no fit here: advance to the next open chunk
                        done  = 1'b0;
                        n_idx = r_idx + OPEN_W'(1);
                    end
                end else if (r_open < OPEN_W'(NUM_CHUNKS)) begin
                    wr_en             = 1'b1;
                    wr_addr           = r_open[IDX_W-1:0];
                    wr_data           = r_req.request_size;
                    n_open            = r_open + OPEN_W'(1);
                    n_out.status      = ST_OK;
                    n_out.grant_chunk = GCHUNK_W'(r_open);
                end else begin
                    n_out.status = ST_NO_CHUNK;
                end
            end
            KIND_QUERY: begin
                n_out.owned = (OPEN_W'(r_req.query_chunk) < r_open)
                              && ({1'b0, r_req.query_offset} < rd_fill);
            end
            KIND_RELEASE: begin
                n_open       = '0;
                n_out.status = ST_RELEASED;
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    assign commit = (r_state == S_RUN) && done && out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_open      <= '0;
            r_capacity  <= CAPACITY_RESET;
            r_max_align <= MAX_ALIGN_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_CAPACITY:  r_capacity  <= i_cfg_data;
                    REG_MAX_ALIGN: r_max_align <= i_cfg_data[MAXAL_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == S_IDLE && i_in_valid) begin
                r_req <= i_in_data;
                r_idx <= '0;
            end else if (r_state == S_RUN && !done) begin
                r_idx <= n_idx;
            end
            if (commit) begin
                r_out       <= n_out;
                r_out_valid <= 1'b1;
                r_open      <= n_open;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Fill levels: one write port, read through the shared unit
    always_ff @(posedge i_clk) begin
        if (commit && wr_en) begin
            r_fill[wr_addr] <= wr_data;
        end
    end

endmodule

>>> tb/sv/tb_chunked_bump_allocator.sv
`timescale 1ns / 1ps
// Testbench for chunked_bump_allocator: a directed plan, then random phases under
// several register settings, all checked against a first-fit predictor kept here.
// Depends on cba_pkg and the chunked_bump_allocator RTL.
module tb_chunked_bump_allocator;
    import cba_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 75;
    localparam int PLAN_ROWS   = 32;

    localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;

    typedef struct packed {
        logic                  wr;     // register write instead of an item
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        t_alloc_req            req;
        logic [4:0]            reps;
        logic                  known;  // answer typed in the row
        t_alloc_rsp            ans;
    } t_plan_row;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_alloc_req            in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_alloc_rsp            out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // allocator image
    logic [FILL_W-1:0]     fill_lvl [NUM_CHUNKS];
    logic [OPEN_W-1:0]     open_cnt;
    logic [CFG_DATA_W-1:0] cap_reg;
    logic [MAXAL_W-1:0]    align_cap;

    t_alloc_rsp answers_due [$];
    t_plan_row  plan [PLAN_ROWS];
    int         err_cnt   = 0;
    int         cycles    = 0;
    logic       quiet     = 1'b0;
    int         hold_ask  = 0;
    int         hold_done = 0;
    int         hold_left = 0;

    chunked_bump_allocator i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic compute_answer(input t_alloc_req r, output t_alloc_rsp a);
        int unsigned eff, lg, mask, off, nf;
        bit          done;
        a    = '0;
        done = 1'b0;
        eff  = (cap_reg > MAX_CHUNK_BYTES) ? MAX_CHUNK_BYTES : cap_reg;
        case (r.kind)
            KIND_ALLOC: begin
                lg   = (r.align_log2 < align_cap) ? r.align_log2 : align_cap;
                mask = (1 << lg) - 1;
                if (r.request_size > eff) begin
                    a.status = ST_TOO_BIG;
                end else begin
                    for (int k = 0; k < NUM_CHUNKS && !done; k++) begin
                        if (k < open_cnt) begin
                            off = (fill_lvl[k] + mask) & ~mask;
                            nf  = off + r.request_size;
                            if (nf <= eff) begin
                                fill_lvl[k]    = FILL_W'(nf);
                                a.grant_chunk  = GCHUNK_W'(k);
                                a.grant_offset = GOFF_W'(off);
                                done           = 1'b1;
                            end
                        end
                    end
                    if (!done) begin
                        if (open_cnt < NUM_CHUNKS) begin
                            // open the next chunk at offset zero
                            a.grant_chunk                     = GCHUNK_W'(open_cnt);
                            fill_lvl[open_cnt[IDX_W-1:0]]     = r.request_size;
                            open_cnt                          = open_cnt + 1'b1;
                        end else begin
                            a.status = ST_NO_CHUNK;
                        end
                    end
                end
            end
            KIND_QUERY: begin
                if (r.query_chunk < open_cnt && r.query_offset < fill_lvl[r.query_chunk])
                    a.owned = 1'b1;
            end
            KIND_RELEASE: begin
                foreach (fill_lvl[k]) fill_lvl[k] = '0;
                open_cnt = '0;
                a.status = ST_RELEASED;
            end
            default: ;
        endcase
    endtask

    function automatic t_alloc_req rq(input logic [KIND_W-1:0] kind, input int unsigned sz,
                                      input int unsigned al, input int unsigned qc,
                                      input int unsigned qo);
        return '{kind, SIZE_W'(sz), ALIGN_W'(al), QCHUNK_W'(qc), QOFF_W'(qo)};
    endfunction

    function automatic t_alloc_rsp rs(input logic [STATUS_W-1:0] st, input int unsigned ch,
                                      input int unsigned off, input logic own);
        return '{st, GCHUNK_W'(ch), GOFF_W'(off), own};
    endfunction

    function automatic t_plan_row row_item(input t_alloc_req r, input int reps,
                                           input logic known, input t_alloc_rsp a);
        return '{1'b0, '0, '0, r, 5'(reps), known, a};
    endfunction

    function automatic t_plan_row row_reg(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        return '{1'b1, idx, val, '0, 5'd0, 1'b0, '0};
    endfunction

    // Mostly allocations and queries aimed at the current fill levels; some noise.
    function automatic t_alloc_req random_req();
        t_alloc_req  r;
        logic [63:0] raw;
        int unsigned eff, f, o, roll;
        raw  = {$urandom, $urandom};
        r    = raw[$bits(t_alloc_req)-1:0];
        eff  = (cap_reg > MAX_CHUNK_BYTES) ? MAX_CHUNK_BYTES : cap_reg;
        roll = $urandom_range(99);
        if (roll < 55) begin
            r.kind       = KIND_ALLOC;
            r.align_log2 = ALIGN_W'($urandom_range(15));
            case ($urandom_range(9))
                0:       r.request_size = '0;
                1:       r.request_size = SIZE_W'($urandom_range(17'h1FFFF));
                2:       r.request_size = SIZE_W'(eff);
                3:       r.request_size = SIZE_W'(eff + 1);
                default: r.request_size = SIZE_W'($urandom_range(eff / 6 + 1));
            endcase
        end else if (roll < 85) begin
            r.kind = KIND_QUERY;
            o      = $urandom_range(open_cnt);
            if (o > 15 || $urandom_range(3) == 0)
                o = $urandom_range(15);
            r.query_chunk = QCHUNK_W'(o);
            f = fill_lvl[r.query_chunk];
            case ($urandom_range(3))
                0:       o = (f == 0) ? 0 : f - 1;
                1:       o = f;
                2:       o = (f == 0) ? 0 : $urandom_range(f - 1);
                default: o = $urandom_range(16'hFFFF);
            endcase
            r.query_offset = QOFF_W'((o > 16'hFFFF) ? 16'hFFFF : o);
        end else if (roll < 88) begin
            r.kind = KIND_RELEASE;
        end else if (roll < 90) begin
            r.kind = KIND_UNUSED;
        end
        return r;
    endfunction

    task automatic send_item(input t_alloc_req r, input logic known, input t_alloc_rsp ans);
        t_alloc_rsp a;
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 12) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do @(posedge clk); while (in_ready !== 1'b1);
        compute_answer(r, a);
        answers_due.push_back(known ? ans : a);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (answers_due.size() != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        if (idx == REG_CAPACITY)
            cap_reg = val;
        else if (idx == REG_MAX_ALIGN)
            align_cap = val[MAXAL_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge clk) begin
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_ask != hold_done) begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= hold_ask;
        end else begin
            out_ready <= quiet || ($urandom_range(99) >= 12);
        end
    end

    always @(posedge clk) begin : check_answers
        t_alloc_rsp want;
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            if (answers_due.size() == 0) begin
                $error("result word with nothing outstanding: %h", out_data);
                err_cnt++;
            end else begin
                want = answers_due.pop_front();
                if (out_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_data.status);
                    err_cnt++;
                end
                if (out_data.grant_chunk !== want.grant_chunk) begin
                    $error("grant_chunk: expected %0d, got %0d",
                           want.grant_chunk, out_data.grant_chunk);
                    err_cnt++;
                end
                if (out_data.grant_offset !== want.grant_offset) begin
                    $error("grant_offset: expected %0d, got %0d",
                           want.grant_offset, out_data.grant_offset);
                    err_cnt++;
                end
                if (out_data.owned !== want.owned) begin
                    $error("owned: expected %0d, got %0d", want.owned, out_data.owned);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("chunked_bump_allocator: mismatch");
            $finish;
        end
    end

    initial begin : main_flow
        t_alloc_req            r;
        int                    counted;
        logic [CFG_DATA_W-1:0] cap_pick;
        logic [CFG_DATA_W-1:0] align_pick;
        foreach (fill_lvl[k]) fill_lvl[k] = '0;
        open_cnt  = '0;
        cap_reg   = CAPACITY_RESET;
        align_cap = MAX_ALIGN_RESET;
        plan = '{
            // reset settings: capacity 8192, alignment cap 16
            row_item(rq(KIND_QUERY, 0, 0, 0, 0), 1, 1, rs(ST_OK, 0, 0, 0)),
            row_item(rq(KIND_ALLOC, 0, 0, 0, 0), 1, 1, rs(ST_OK, 0, 0, 0)),
            row_item(rq(KIND_ALLOC, 8193, 0, 0, 0), 1, 1, rs(ST_TOO_BIG, 0, 0, 0)),
            row_item(rq(KIND_ALLOC, 17'h1FFFF, 15, 0, 0), 1, 1, rs(ST_TOO_BIG, 0, 0, 0)),
            row_item(rq(KIND_ALLOC, 8192, 0, 0, 0), 1, 1, rs(ST_OK, 0, 0, 0)),
            row_item(rq(KIND_ALLOC, 1, 15, 0, 0), 1, 1, rs(ST_OK, 1, 0, 0)),
            row_item(rq(KIND_ALLOC, 3, 12, 0, 0), 1, 1, rs(ST_OK, 1, 16, 0)),
            row_item(rq(KIND_QUERY, 0, 0, 1, 18), 1, 1, rs(ST_OK, 0, 0, 1)),
            row_item(rq(KIND_QUERY, 0, 0, 1, 19), 1, 1, rs(ST_OK, 0, 0, 0)),
            row_item(rq(KIND_QUERY, 0, 0, 15, 16'hFFFF), 1, 1, rs(ST_OK, 0, 0, 0)),
            row_item(rq(KIND_UNUSED, 17'h1FFFF, 15, 15, 16'hFFFF), 1, 1, rs(ST_OK, 0, 0, 0)),
            row_item(rq(KIND_RELEASE, 0, 0, 0, 0), 1, 1, rs(ST_RELEASED, 0, 0, 0)),
            // capacity above the limit, widest alignment cap
            row_reg(REG_CAPACITY, 17'h1FFFF),
            row_reg(REG_MAX_ALIGN, 17'd7),
            row_item(rq(KIND_ALLOC, 65536, 0, 0, 0), 1, 1, rs(ST_OK, 0, 0, 0)),
            row_item(rq(KIND_ALLOC, 65537, 0, 0, 0), 1, 1, rs(ST_TOO_BIG, 0, 0, 0)),
            row_item(rq(KIND_ALLOC, 1, 15, 0, 0), 1, 1, rs(ST_OK, 1, 0, 0)),
            row_item(rq(KIND_ALLOC, 5, 7, 0, 0), 1, 1, rs(ST_OK, 1, 128, 0)),
            row_item(rq(KIND_QUERY, 0, 0, 0, 16'hFFFF), 1, 1, rs(ST_OK, 0, 0, 1)),
            row_item(rq(KIND_RELEASE, 0, 0, 0, 0), 1, 1, rs(ST_RELEASED, 0, 0, 0)),
            // zero capacity: only empty requests fit
            row_reg(REG_CAPACITY, 17'd0),
            row_item(rq(KIND_ALLOC, 0, 3, 0, 0), 1, 1, rs(ST_OK, 0, 0, 0)),
            row_item(rq(KIND_ALLOC, 1, 0, 0, 0), 1, 1, rs(ST_TOO_BIG, 0, 0, 0)),
            row_item(rq(KIND_QUERY, 0, 0, 0, 0), 1, 1, rs(ST_OK, 0, 0, 0)),
            row_item(rq(KIND_RELEASE, 0, 0, 0, 0), 1, 1, rs(ST_RELEASED, 0, 0, 0)),
            // one-byte chunks: open all of them, then run out
            row_reg(REG_CAPACITY, 17'd1),
            row_reg(REG_MAX_ALIGN, 17'd0),
            row_item(rq(KIND_ALLOC, 1, 0, 0, 0), 16, 0, '0),
            row_item(rq(KIND_ALLOC, 1, 0, 0, 0), 1, 1, rs(ST_NO_CHUNK, 0, 0, 0)),
            row_item(rq(KIND_ALLOC, 0, 9, 0, 0), 1, 1, rs(ST_OK, 0, 1, 0)),
            row_item(rq(KIND_QUERY, 0, 0, 15, 0), 1, 1, rs(ST_OK, 0, 0, 1)),
            row_item(rq(KIND_RELEASE, 0, 0, 0, 0), 1, 1, rs(ST_RELEASED, 0, 0, 0))
        };

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[n]) begin
            if (plan[n].wr) begin
                drain();
                write_reg(plan[n].idx, plan[n].val);
            end else begin
                repeat (plan[n].reps) send_item(plan[n].req, plan[n].known, plan[n].ans);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph % 7)
                0:       cap_pick = CAPACITY_RESET;
                1:       cap_pick = 17'd1;
                2:       cap_pick = 17'h1FFFF;
                3:       cap_pick = CFG_DATA_W'($urandom_range(200, 2));
                4:       cap_pick = 17'd0;
                5:       cap_pick = CAPACITY_LIMIT;
                default: cap_pick = CFG_DATA_W'($urandom_range(65535, 201));
            endcase
            // upper data bits set on the alignment write must be dropped
            if (ph == 0)
                align_pick = 17'h1FFF8;
            else if (ph == 1)
                align_pick = 17'd7;
            else
                align_pick = CFG_DATA_W'($urandom);
            write_reg(REG_MAX_ALIGN, align_pick);
            write_reg(REG_CAPACITY, cap_pick);
            if (ph == 4)
                write_reg(REG_SPARE, CFG_DATA_W'($urandom));
            quiet <= (ph == 6);
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                r = random_req();
                send_item(r, 1'b0, '0);
                if (r.kind != KIND_UNUSED) begin
                    counted++;
                    if (ph == 3 && counted == 10)
                        hold_ask <= hold_ask + 1;
                end
            end
        end

        drain();
        repeat (40) @(negedge clk);
        if (err_cnt == 0)
            $display("chunked_bump_allocator: match");
        else
            $display("chunked_bump_allocator: mismatch");
        $finish;
    end

endmodule

>>> chunked_bump_allocator.f
sv/cba_pkg.sv
sv/chunked_bump_allocator.sv
tb/sv/tb_chunked_bump_allocator.sv
